// ===== rtl/etma_pkg.sv =====
// ----------------------------------------------------------------------------
// etma_pkg
// Shared constants, types and codes for the edge-truncated moving average.
// ----------------------------------------------------------------------------
package etma_pkg;

  localparam int MAX_LEFT    = 32;
  localparam int MAX_RIGHT   = 32;
  localparam int SAMPLE_W    = 24;
  localparam int FRAC_BITS   = 8;

  localparam int STORE_DEPTH = MAX_LEFT + MAX_RIGHT + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SEEN_CAP    = MAX_LEFT + MAX_RIGHT + 2;
  localparam int SEEN_W      = $clog2(SEEN_CAP + 1);

  localparam int HW_W        = 6;    // half-window register width
  localparam int CFG_IDX_W   = 1;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W       = 32;
  localparam int MEAN_W      = 32;
  localparam int DIVD_W      = SUM_W + FRAC_BITS;
  localparam int REM_W       = COUNT_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_START,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic start;
    logic sum_run;
    logic div_init;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_output;
    logic sum_done;
    logic div_done;
    logic out_free;
    logic more;
  } dp_status_t;

endpackage

// ===== rtl/etma_ram.sv =====
// ----------------------------------------------------------------------------
// etma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/etma_ctrl.sv =====
// ----------------------------------------------------------------------------
// etma_ctrl
// Sequencer: accept, set up outputs, sum window, divide, load result.
// ----------------------------------------------------------------------------
module etma_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  etma_pkg::dp_status_t  status,
  output etma_pkg::ctrl_cmd_t   cmd
);

  etma_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      etma_pkg::S_IDLE: begin
        if (in_valid) state_next = etma_pkg::S_SETUP;
      end
      etma_pkg::S_SETUP: begin
        state_next = status.has_output ? etma_pkg::S_START : etma_pkg::S_IDLE;
      end
      etma_pkg::S_START:    state_next = etma_pkg::S_SUM;
      etma_pkg::S_SUM: begin
        if (status.sum_done) state_next = etma_pkg::S_DIV_INIT;
      end
      etma_pkg::S_DIV_INIT: state_next = etma_pkg::S_DIV;
      etma_pkg::S_DIV: begin
        if (status.div_done) state_next = etma_pkg::S_LOAD;
      end
      etma_pkg::S_LOAD: begin
        if (status.out_free) begin
          state_next = status.more ? etma_pkg::S_START : etma_pkg::S_IDLE;
        end
      end
      default: state_next = etma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      etma_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      etma_pkg::S_SETUP:    cmd.setup    = 1'b1;
      etma_pkg::S_START:    cmd.start    = 1'b1;
      etma_pkg::S_SUM:      cmd.sum_run  = 1'b1;
      etma_pkg::S_DIV_INIT: cmd.div_init = 1'b1;
      etma_pkg::S_DIV:      cmd.div_step = 1'b1;
      etma_pkg::S_LOAD:     cmd.load     = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/etma_dp.sv =====
// ----------------------------------------------------------------------------
// etma_dp
// Datapath: sample store, window accumulator, restoring divider, output reg.
// ----------------------------------------------------------------------------
module etma_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [etma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [etma_pkg::HW_W-1:0]             cfg_data,
  input  logic signed [etma_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  end_of_record,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [etma_pkg::MEAN_W-1:0]    window_mean,
  output logic                                  last_of_record,
  input  etma_pkg::ctrl_cmd_t                   cmd,
  output etma_pkg::dp_status_t                  status
);

  localparam int AW = etma_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(etma_pkg::STORE_DEPTH - 1);

  // configuration and record position
  logic [etma_pkg::HW_W-1:0]    left_hw, right_hw;
  logic [AW-1:0]                wp;
  logic [etma_pkg::SEEN_W-1:0]  seen;
  logic                         last_flag;

  // per-record output sequencing
  logic [AW-1:0]                base_slot;
  logic [etma_pkg::SEEN_W-1:0]  newest_idx;
  logic [etma_pkg::HW_W-1:0]    back;

  // accumulation
  logic [AW-1:0]                rd_addr;
  logic [etma_pkg::COUNT_W-1:0] remain, count;
  logic                         rd_valid;
  logic [etma_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [etma_pkg::SUM_W-1:0] sum;

  // divider
  logic [etma_pkg::DIVD_W-1:0]    quo;
  logic [etma_pkg::REM_W-1:0]     rem;
  logic [etma_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           neg;

  etma_ram #(
    .WIDTH(etma_pkg::SAMPLE_W),
    .DEPTH(etma_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(wp),
    .wdata(sample),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // combinational helpers
  logic [etma_pkg::SEEN_W-1:0]  newest, right_ext, first_back, k_idx, left_ext, left_cut;
  logic [etma_pkg::HW_W-1:0]    cfg_clamped_l, cfg_clamped_r;
  logic [etma_pkg::COUNT_W-1:0] count_new;
  logic [etma_pkg::REM_W-1:0]   rem_shift;
  logic [etma_pkg::SUM_W-1:0]   sum_mag;
  logic [etma_pkg::MEAN_W-1:0]  mean_sat;
  logic                         quo_big;

  always_comb begin
    cfg_clamped_l = (cfg_data > etma_pkg::HW_W'(etma_pkg::MAX_LEFT))
                    ? etma_pkg::HW_W'(etma_pkg::MAX_LEFT) : cfg_data;
    cfg_clamped_r = (cfg_data > etma_pkg::HW_W'(etma_pkg::MAX_RIGHT))
                    ? etma_pkg::HW_W'(etma_pkg::MAX_RIGHT) : cfg_data;

    newest     = seen - etma_pkg::SEEN_W'(1);
    right_ext  = etma_pkg::SEEN_W'(right_hw);
    first_back = (newest < right_ext) ? newest : right_ext;

    // window for the output "back" samples behind the newest one
    k_idx     = newest_idx - etma_pkg::SEEN_W'(back);
    left_ext  = etma_pkg::SEEN_W'(left_hw);
    left_cut  = (k_idx < left_ext) ? k_idx : left_ext;
    count_new = etma_pkg::COUNT_W'(left_cut) + etma_pkg::COUNT_W'(back)
                + etma_pkg::COUNT_W'(1);

    rem_shift = {rem[etma_pkg::REM_W-2:0], quo[etma_pkg::DIVD_W-1]};

    sum_mag = sum[etma_pkg::SUM_W-1] ? etma_pkg::SUM_W'(-sum) : etma_pkg::SUM_W'(sum);

    // quotient magnitude of 2^31 or more saturates
    quo_big = |quo[etma_pkg::DIVD_W-1:etma_pkg::MEAN_W-1];
    if (neg) begin
      mean_sat = quo_big ? {1'b1, {(etma_pkg::MEAN_W-1){1'b0}}}
                         : etma_pkg::MEAN_W'(-quo[etma_pkg::MEAN_W-1:0]);
    end else begin
      mean_sat = quo_big ? {1'b0, {(etma_pkg::MEAN_W-1){1'b1}}}
                         : quo[etma_pkg::MEAN_W-1:0];
    end
  end

  always_comb begin
    status.has_output = last_flag || (newest >= right_ext);
    status.sum_done   = (remain == '0) && !rd_valid;
    status.div_done   = (div_cnt == '0);
    status.out_free   = !out_valid || out_ready;
    status.more       = last_flag && (back != '0);
  end

  // record position and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      left_hw  <= '0;
      right_hw <= '0;
      wp       <= '0;
      seen     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        etma_pkg::REG_LEFT:  left_hw  <= cfg_clamped_l;
        etma_pkg::REG_RIGHT: right_hw <= cfg_clamped_r;
        default: ;
      endcase
      wp   <= '0;
      seen <= '0;
    end else if (cmd.accept) begin
      wp <= (wp == LAST_SLOT) ? '0 : wp + AW'(1);
      if (seen != etma_pkg::SEEN_W'(etma_pkg::SEEN_CAP)) begin
        seen <= seen + etma_pkg::SEEN_W'(1);
      end
    end else if (cmd.setup && last_flag) begin
      // record done: the flush works from the captured base
      wp   <= '0;
      seen <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_flag <= end_of_record;
    end
    if (cmd.setup) begin
      base_slot  <= (wp == '0) ? LAST_SLOT : wp - AW'(1);
      newest_idx <= newest;
      back       <= last_flag ? etma_pkg::HW_W'(first_back) : right_hw;
    end else if (cmd.load && status.more) begin
      back <= back - etma_pkg::HW_W'(1);
    end
  end

  // window accumulation, one store read per cycle, newest slot backward
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      remain   <= '0;
    end else if (cmd.start) begin
      rd_valid <= 1'b0;
      remain   <= count_new;
    end else if (cmd.sum_run) begin
      rd_valid <= (remain != '0);
      if (remain != '0) begin
        remain <= remain - etma_pkg::COUNT_W'(1);
      end
    end else begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr <= base_slot;
      count   <= count_new;
      sum     <= '0;
    end else if (cmd.sum_run) begin
      if (remain != '0) begin
        rd_addr <= (rd_addr == '0) ? LAST_SLOT : rd_addr - AW'(1);
      end
      if (rd_valid) begin
        sum <= sum + {{(etma_pkg::SUM_W-etma_pkg::SAMPLE_W){rd_data[etma_pkg::SAMPLE_W-1]}},
                      rd_data};
      end
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= etma_pkg::DIV_CNT_W'(etma_pkg::DIVD_W);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - etma_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo <= {sum_mag, {etma_pkg::FRAC_BITS{1'b0}}};
      rem <= '0;
      neg <= sum[etma_pkg::SUM_W-1];
    end else if (cmd.div_step && div_cnt != '0) begin
      if (rem_shift >= etma_pkg::REM_W'(count)) begin
        rem <= rem_shift - etma_pkg::REM_W'(count);
        quo <= {quo[etma_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[etma_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      window_mean    <= mean_sat;
      last_of_record <= last_flag && (back == '0);
    end
  end

endmodule

// ===== rtl/edge_truncated_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// edge_truncated_moving_average_core
// Centered moving average with record-edge truncation, 8 fraction bits.
// ----------------------------------------------------------------------------
// Flow: accept, setup, start, window sum (store reads, newest slot backward),
//   divider init, divider steps until done, then load into the output register.
// Pacing: set by the single store read port and the divider; a new sample
//   is taken only after every output due for the last one has been loaded.
//   A flush emits up to 33 outputs.
// Reset (rst, sync): half-windows 0, record cleared; store not cleared.
// ----------------------------------------------------------------------------
module edge_truncated_moving_average_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration: index 0 left half-window, 1 right half-window
  input  logic                                  cfg_wr_en,
  input  logic [etma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [etma_pkg::HW_W-1:0]             cfg_data,
  // input transactions
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [etma_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  end_of_record,
  // output transactions
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [etma_pkg::MEAN_W-1:0]    window_mean,
  output logic                                  last_of_record
);

  etma_pkg::ctrl_cmd_t  cmd;
  etma_pkg::dp_status_t status;

  // Controller sequences each transaction: store the sample, decide how
  // many outputs are due, then per output sum the window and divide.
  etma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // Datapath holds the sample ring, accumulator, divider and the output
  // register, so a finished mean can wait while the next sample comes in.
  etma_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .end_of_record (end_of_record),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .window_mean   (window_mean),
    .last_of_record(last_of_record),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
